[rtl/positional_array_list_macros.svh]
// Assertion macros shared by the positional array list RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge, skipped while reset is asserted.
`define PAL_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("positional array list assertion failed");
// Checked at every rising edge, reset included.
`define PAL_ASSERT_NR(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("positional array list assertion failed");
`else
`define PAL_ASSERT(lbl, ck, rn, prop)
`define PAL_ASSERT_NR(lbl, ck, prop)
`endif

`endif

[rtl/pal_pkg.sv]
// Package for the positional array list: sizes, codes, microcode word format
// and the microcode program itself. No dependencies.
package pal_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 7;
    // Comparison width: wide enough for a position, a count and one more.
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int PC_W     = 5;

    typedef enum logic [1:0] {
        CMD_GET,
        CMD_SEARCH,
        CMD_INSERT,
        CMD_DELETE
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_POS,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef enum logic [3:0] {
        UOP_LATCH,
        UOP_NOP,
        UOP_INIT,
        UOP_MOVE_DOWN,
        UOP_DEC_CNT,
        UOP_GET_RD,
        UOP_EMIT_GET,
        UOP_SRCH_STEP,
        UOP_EMIT_NF,
        UOP_MOVE_UP,
        UOP_WR_VAL,
        UOP_EMIT_FULL,
        UOP_EMIT_OK,
        UOP_EMIT_FOUND,
        UOP_EMIT_BAD
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_BAD,
        C_GET,
        C_SRCH,
        C_INS,
        C_MORE,
        C_HIT,
        C_FULL
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE      = pc_t'(0);
    localparam pc_t STEP_INIT      = pc_t'(1);
    localparam pc_t STEP_DISP_GET  = pc_t'(2);
    localparam pc_t STEP_DISP_SRCH = pc_t'(3);
    localparam pc_t STEP_DISP_INS  = pc_t'(4);
    localparam pc_t STEP_DEL_LOOP  = pc_t'(5);
    localparam pc_t STEP_DEL_CNT   = pc_t'(6);
    localparam pc_t STEP_GET_RD    = pc_t'(7);
    localparam pc_t STEP_GET_OUT   = pc_t'(8);
    localparam pc_t STEP_SRCH_LOOP = pc_t'(9);
    localparam pc_t STEP_SRCH_HIT  = pc_t'(10);
    localparam pc_t STEP_SRCH_MISS = pc_t'(11);
    localparam pc_t STEP_INS_CHK   = pc_t'(12);
    localparam pc_t STEP_INS_LOOP  = pc_t'(13);
    localparam pc_t STEP_INS_WR    = pc_t'(14);
    localparam pc_t STEP_OUT_FULL  = pc_t'(15);
    localparam pc_t STEP_OUT_OK    = pc_t'(16);
    localparam pc_t STEP_OUT_FOUND = pc_t'(17);
    localparam pc_t STEP_OUT_BAD   = pc_t'(18);

    // One control word: datapath operation, jump condition, jump target.
    // When the condition is false the step counter advances by one.
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // Status flags from the datapath back to the sequencer.
    typedef struct packed {
        logic bad;
        logic full;
        logic more;
        logic hit;
        cmd_t cmd;
    } flags_t;

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        case (pc)
            STEP_IDLE:      w = '{UOP_LATCH,      C_NOSTART, STEP_IDLE};
            STEP_INIT:      w = '{UOP_INIT,       C_BAD,     STEP_OUT_BAD};
            STEP_DISP_GET:  w = '{UOP_NOP,        C_GET,     STEP_GET_RD};
            STEP_DISP_SRCH: w = '{UOP_NOP,        C_SRCH,    STEP_SRCH_LOOP};
            STEP_DISP_INS:  w = '{UOP_NOP,        C_INS,     STEP_INS_CHK};
            STEP_DEL_LOOP:  w = '{UOP_MOVE_DOWN,  C_MORE,    STEP_DEL_LOOP};
            STEP_DEL_CNT:   w = '{UOP_DEC_CNT,    C_ALWAYS,  STEP_OUT_OK};
            STEP_GET_RD:    w = '{UOP_GET_RD,     C_NEVER,   STEP_IDLE};
            STEP_GET_OUT:   w = '{UOP_EMIT_GET,   C_ALWAYS,  STEP_IDLE};
            STEP_SRCH_LOOP: w = '{UOP_SRCH_STEP,  C_MORE,    STEP_SRCH_LOOP};
            STEP_SRCH_HIT:  w = '{UOP_NOP,        C_HIT,     STEP_OUT_FOUND};
            STEP_SRCH_MISS: w = '{UOP_EMIT_NF,    C_ALWAYS,  STEP_IDLE};
            STEP_INS_CHK:   w = '{UOP_NOP,        C_FULL,    STEP_OUT_FULL};
            STEP_INS_LOOP:  w = '{UOP_MOVE_UP,    C_MORE,    STEP_INS_LOOP};
            STEP_INS_WR:    w = '{UOP_WR_VAL,     C_ALWAYS,  STEP_OUT_OK};
            STEP_OUT_FULL:  w = '{UOP_EMIT_FULL,  C_ALWAYS,  STEP_IDLE};
            STEP_OUT_OK:    w = '{UOP_EMIT_OK,    C_ALWAYS,  STEP_IDLE};
            STEP_OUT_FOUND: w = '{UOP_EMIT_FOUND, C_ALWAYS,  STEP_IDLE};
            STEP_OUT_BAD:   w = '{UOP_EMIT_BAD,   C_ALWAYS,  STEP_IDLE};
            default:        w = '{UOP_NOP,        C_ALWAYS,  STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/pal_dpath.sv]
// Datapath of the positional array list: entry memory, count, walk pointer
// and result registers. Depends on pal_pkg and the assertion macro header.
`include "positional_array_list_macros.svh"

module pal_dpath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               command,
    input  logic [pal_pkg::POS_W-1:0] position,
    input  logic [pal_pkg::VAL_W-1:0] value,
    input  pal_pkg::uword_t          uw,
    output pal_pkg::flags_t          flags,
    output logic                     done,
    output pal_pkg::status_t         status,
    output logic [pal_pkg::LEN_W-1:0] found_position,
    output logic [pal_pkg::VAL_W-1:0] read_value,
    output logic [pal_pkg::LEN_W-1:0] length
);
    import pal_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];

    cmd_t             cmd_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] rdata_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pend_addr_reg, pend_addr_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    status_t          status_reg, status_next;
    logic [LEN_W-1:0] found_reg, found_next;
    logic [VAL_W-1:0] rd_reg, rd_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [CMP_W-1:0] pos_x, cnt_x, idx_x, pos_m1, found_x;
    logic [CNT_W-1:0] idx_m1, idx_p1;
    logic             bad, full, hit, more;
    logic             ren, wen;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [VAL_W-1:0] wdata;
    logic             emit;

    assign pos_x   = CMP_W'(pos_reg);
    assign cnt_x   = CMP_W'(count_reg);
    assign idx_x   = CMP_W'(idx_reg);
    assign pos_m1  = pos_x - CMP_W'(1);
    assign found_x = CMP_W'(pend_addr_reg) + CMP_W'(1);
    assign idx_m1  = idx_reg - CNT_W'(1);
    assign idx_p1  = idx_reg + CNT_W'(1);

    assign full = (cnt_x == CMP_W'(CAPACITY));
    assign hit  = pend_reg && (rdata_reg == val_reg);

    always_comb
    begin
        case (cmd_reg)
            CMD_SEARCH: bad = 1'b0;
            CMD_INSERT: bad = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
            default:    bad = (pos_x == '0) || (pos_x > cnt_x);
        endcase
    end

    // Loop condition of the walk that the current step performs.
    always_comb
    begin
        case (uw.op)
            UOP_SRCH_STEP: more = !hit && (idx_x < cnt_x);
            UOP_MOVE_UP:   more = (idx_x >= pos_x);
            UOP_MOVE_DOWN: more = (idx_x + CMP_W'(1) < cnt_x);
            default:       more = 1'b0;
        endcase
    end

    assign flags = '{bad: bad, full: full, more: more, hit: hit, cmd: cmd_reg};

    // Memory port control. A move reads the next source entry while the entry
    // read in the previous cycle is written to its new place.
    always_comb
    begin
        ren   = 1'b0;
        wen   = 1'b0;
        raddr = '0;
        waddr = pend_addr_reg[ADDR_W-1:0];
        wdata = rdata_reg;
        case (uw.op)
            UOP_GET_RD:
            begin
                ren   = 1'b1;
                raddr = pos_m1[ADDR_W-1:0];
            end
            UOP_SRCH_STEP:
            begin
                ren   = more;
                raddr = idx_reg[ADDR_W-1:0];
            end
            UOP_MOVE_UP:
            begin
                ren   = more;
                raddr = idx_m1[ADDR_W-1:0];
                wen   = pend_reg;
            end
            UOP_MOVE_DOWN:
            begin
                ren   = more;
                raddr = idx_p1[ADDR_W-1:0];
                wen   = pend_reg;
            end
            UOP_WR_VAL:
            begin
                wen   = 1'b1;
                waddr = pos_m1[ADDR_W-1:0];
                wdata = val_reg;
            end
            default:
            begin
                ren = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        emit           = 1'b0;
        status_next    = status_reg;
        found_next     = '0;
        rd_next        = '0;
        case (uw.op)
            UOP_INIT:
            begin
                pend_next = 1'b0;
                case (cmd_reg)
                    CMD_SEARCH: idx_next = '0;
                    CMD_INSERT: idx_next = count_reg;
                    CMD_DELETE: idx_next = pos_m1[CNT_W-1:0];
                    default:    idx_next = idx_reg;
                endcase
            end
            UOP_SRCH_STEP:
            begin
                // On exit the last read stays pending so that a hit can be seen.
                if (more)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_p1;
                end
            end
            UOP_MOVE_UP:
            begin
                pend_next = more;
                if (more)
                begin
                    pend_addr_next = idx_reg;
                    idx_next       = idx_m1;
                end
            end
            UOP_MOVE_DOWN:
            begin
                pend_next = more;
                if (more)
                begin
                    pend_addr_next = idx_reg;
                    idx_next       = idx_p1;
                end
            end
            UOP_DEC_CNT:    count_next = count_reg - CNT_W'(1);
            UOP_WR_VAL:     count_next = count_reg + CNT_W'(1);
            UOP_EMIT_GET:
            begin
                emit        = 1'b1;
                status_next = ST_OK;
                rd_next     = rdata_reg;
            end
            UOP_EMIT_FOUND:
            begin
                emit        = 1'b1;
                status_next = ST_OK;
                found_next  = found_x[LEN_W-1:0];
            end
            UOP_EMIT_OK:
            begin
                emit        = 1'b1;
                status_next = ST_OK;
            end
            UOP_EMIT_NF:
            begin
                emit        = 1'b1;
                status_next = ST_NOT_FOUND;
            end
            UOP_EMIT_FULL:
            begin
                emit        = 1'b1;
                status_next = ST_FULL;
            end
            UOP_EMIT_BAD:
            begin
                emit        = 1'b1;
                status_next = ST_BAD_POS;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        done_next = emit;
        len_next  = cnt_x[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        if (uw.op == UOP_LATCH && start)
        begin
            cmd_reg <= cmd_t'(command);
            pos_reg <= position;
            val_reg <= value;
        end
        if (emit)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            rd_reg     <= rd_next;
            len_reg    <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = rd_reg;
    assign length         = len_reg;

    `PAL_ASSERT(a_count_bound, clk, rst_n, cnt_x <= CMP_W'(CAPACITY))
    `PAL_ASSERT(a_done_single, clk, rst_n, done_reg |=> !done_reg)
    `PAL_ASSERT(a_found_ok, clk, rst_n, (done_reg && found_reg != '0) |-> (status_reg == ST_OK))
    `PAL_ASSERT(a_no_rw_clash, clk, rst_n, !(ren && wen && raddr == waddr))

endmodule

[rtl/pal_ctrl.sv]
// Microcoded sequencer of the positional array list: step counter, control
// word ROM and jump logic. Depends on pal_pkg and the assertion macro header.
`include "positional_array_list_macros.svh"

module pal_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pal_pkg::flags_t flags,
    output pal_pkg::uword_t uw,
    output logic            busy
);
    import pal_pkg::*;

    pc_t  pc_reg, pc_next;
    logic take;

    assign uw = ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NOSTART: take = !start;
            C_BAD:     take = flags.bad;
            C_GET:     take = (flags.cmd == CMD_GET);
            C_SRCH:    take = (flags.cmd == CMD_SEARCH);
            C_INS:     take = (flags.cmd == CMD_INSERT);
            C_MORE:    take = flags.more;
            C_HIT:     take = flags.hit;
            C_FULL:    take = flags.full;
            default:   take = 1'b0;
        endcase
        pc_next = take ? uw.target : pc_reg + pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign busy = (pc_reg != STEP_IDLE);

    `PAL_ASSERT(a_accept_init, clk, rst_n, (start && !busy) |=> (pc_reg == STEP_INIT))

endmodule

[rtl/positional_array_list.sv]
// Top level of the positional array list: ports, sequencer and datapath.
// Depends on pal_pkg, pal_ctrl and pal_dpath.
//
// A request is taken when start is high and busy is low; its result appears
// for exactly one cycle with done high, and the receiver cannot stall it.
// One request is in work at a time. The entries sit in a memory with one
// write and one registered read port, and a microcoded sequencer walks it one
// entry per cycle: search walks up to the whole list, insert and delete
// move the entries from the position to the end, and a bad position or an
// insert into a full list ends without a walk. busy is already low while
// done is high, so the next request can be taken in the cycle that carries
// the result.
module positional_array_list (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       command,
    input  logic [pal_pkg::POS_W-1:0]        position,
    input  logic signed [pal_pkg::VAL_W-1:0] value,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [pal_pkg::LEN_W-1:0]        found_position,
    output logic signed [pal_pkg::VAL_W-1:0] read_value,
    output logic [pal_pkg::LEN_W-1:0]        length
);
    import pal_pkg::*;

    uword_t  uw;
    flags_t  flags;
    status_t status_w;

    pal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .uw    (uw),
        .busy  (busy)
    );

    pal_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .position       (position),
        .value          (value),
        .uw             (uw),
        .flags          (flags),
        .done           (done),
        .status         (status_w),
        .found_position (found_position),
        .read_value     (read_value),
        .length         (length)
    );

    assign status = status_w;

endmodule
